>>> hdl/alu8_pkg.sv
`timescale 1ns / 1ps

package alu8_pkg;

    localparam int unsigned DATA_W  = 8;
    localparam int unsigned FUNC_W  = 5;
    localparam int unsigned INDEX_W = 3;

    localparam logic [3:0]        NIBBLE_MAX  = 4'hF;
    localparam logic [3:0]        BCD_MAX     = 4'h9;
    localparam logic [DATA_W-1:0] DAA_LIMIT   = 8'h99;
    localparam logic [DATA_W-1:0] DAA_ADJ_LO  = 8'h06;
    localparam logic [DATA_W-1:0] DAA_ADJ_HI  = 8'h60;
    localparam logic [DATA_W-1:0] BYTE_ONES   = 8'hFF;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_ADD  = 5'd0,
        FUNC_ADC  = 5'd1,
        FUNC_SUB  = 5'd2,
        FUNC_SBC  = 5'd3,
        FUNC_AND  = 5'd4,
        FUNC_XOR  = 5'd5,
        FUNC_OR   = 5'd6,
        FUNC_CP   = 5'd7,
        FUNC_INC  = 5'd8,
        FUNC_DEC  = 5'd9,
        FUNC_RLCA = 5'd10,
        FUNC_RRCA = 5'd11,
        FUNC_RLA  = 5'd12,
        FUNC_RRA  = 5'd13,
        FUNC_DAA  = 5'd14,
        FUNC_CPL  = 5'd15,
        FUNC_SCF  = 5'd16,
        FUNC_CCF  = 5'd17,
        FUNC_RLC  = 5'd18,
        FUNC_RRC  = 5'd19,
        FUNC_RL   = 5'd20,
        FUNC_RR   = 5'd21,
        FUNC_SLA  = 5'd22,
        FUNC_SRA  = 5'd23,
        FUNC_SWAP = 5'd24,
        FUNC_BIT  = 5'd25,
        FUNC_RES  = 5'd26,
        FUNC_SET  = 5'd27
    } t_func;

    typedef struct packed {
        t_func               func;
        logic [DATA_W-1:0]   accumulator;
        logic [DATA_W-1:0]   operand;
        logic [INDEX_W-1:0]  bit_index;
        logic                zero_in;
        logic                subtract_in;
        logic                half_carry_in;
        logic                carry_in;
    } t_in_item;

    typedef struct packed {
        logic [DATA_W-1:0]   result;
        logic                zero_out;
        logic                subtract_out;
        logic                half_carry_out;
        logic                carry_out;
    } t_out_item;

endpackage

>>> hdl/alu8_in_if.sv
`timescale 1ns / 1ps

interface alu8_in_if;
    logic                             valid;
    logic                             ready;
    logic [alu8_pkg::FUNC_W-1:0]      func;
    logic [alu8_pkg::DATA_W-1:0]      accumulator;
    logic [alu8_pkg::DATA_W-1:0]      operand;
    logic [alu8_pkg::INDEX_W-1:0]     bit_index;
    logic                             zero_in;
    logic                             subtract_in;
    logic                             half_carry_in;
    logic                             carry_in;

    modport source (
        output valid, func, accumulator, operand, bit_index,
               zero_in, subtract_in, half_carry_in, carry_in,
        input  ready
    );

    modport sink (
        input  valid, func, accumulator, operand, bit_index,
               zero_in, subtract_in, half_carry_in, carry_in,
        output ready
    );
endinterface

>>> hdl/alu8_out_if.sv
`timescale 1ns / 1ps

interface alu8_out_if;
    logic                          valid;
    logic                          ready;
    logic [alu8_pkg::DATA_W-1:0]   result;
    logic                          zero_out;
    logic                          subtract_out;
    logic                          half_carry_out;
    logic                          carry_out;

    modport source (
        output valid, result, zero_out, subtract_out, half_carry_out, carry_out,
        input  ready
    );

    modport sink (
        input  valid, result, zero_out, subtract_out, half_carry_out, carry_out,
        output ready
    );
endinterface

>>> hdl/alu8_exec.sv
`timescale 1ns / 1ps

module alu8_exec (
    input  alu8_pkg::t_in_item  i_item,
    output alu8_pkg::t_out_item o_item
);

    logic [alu8_pkg::DATA_W-1:0] a;
    logic [alu8_pkg::DATA_W-1:0] v;
    logic                        cin;
    logic [alu8_pkg::DATA_W:0]   sum9;
    logic [4:0]                  sum_lo;
    logic [alu8_pkg::DATA_W:0]   diff9;
    logic [4:0]                  diff_lo;
    logic [alu8_pkg::DATA_W-1:0] bit_mask;
    logic                        daa_hi;
    logic                        daa_lo;
    logic [alu8_pkg::DATA_W-1:0] daa_adj;
    logic [alu8_pkg::DATA_W-1:0] r;
    logic                        z;
    logic                        n;
    logic                        h;
    logic                        c;
    logic                        zero_from_r;

    assign a = i_item.accumulator;
    assign v = i_item.operand;

    // carry/borrow in only for adc and sbc
    assign cin = ((i_item.func == alu8_pkg::FUNC_ADC) || (i_item.func == alu8_pkg::FUNC_SBC))
                 ? i_item.carry_in : 1'b0;

    assign sum9    = {1'b0, a} + {1'b0, v} + {{alu8_pkg::DATA_W{1'b0}}, cin};
    assign sum_lo  = {1'b0, a[3:0]} + {1'b0, v[3:0]} + {4'd0, cin};
    assign diff9   = {1'b0, a} - {1'b0, v} - {{alu8_pkg::DATA_W{1'b0}}, cin};
    assign diff_lo = {1'b0, a[3:0]} - {1'b0, v[3:0]} - {4'd0, cin};

    assign bit_mask = {{(alu8_pkg::DATA_W-1){1'b0}}, 1'b1} << i_item.bit_index;

    // decimal adjust: both tests look at the unadjusted accumulator
    assign daa_hi  = i_item.subtract_in ? i_item.carry_in
                                        : (i_item.carry_in || (a > alu8_pkg::DAA_LIMIT));
    assign daa_lo  = i_item.subtract_in ? i_item.half_carry_in
                                        : (i_item.half_carry_in || (a[3:0] > alu8_pkg::BCD_MAX));
    assign daa_adj = (daa_hi ? alu8_pkg::DAA_ADJ_HI : '0) | (daa_lo ? alu8_pkg::DAA_ADJ_LO : '0);

    always_comb begin
        r           = a;
        z           = i_item.zero_in;
        n           = i_item.subtract_in;
        h           = i_item.half_carry_in;
        c           = i_item.carry_in;
        zero_from_r = 1'b0;
        case (i_item.func)
            alu8_pkg::FUNC_ADD, alu8_pkg::FUNC_ADC: begin
                r = sum9[alu8_pkg::DATA_W-1:0];
                n = 1'b0;
                h = sum_lo[4];
                c = sum9[alu8_pkg::DATA_W];
                zero_from_r = 1'b1;
            end
            alu8_pkg::FUNC_SUB, alu8_pkg::FUNC_SBC: begin
                r = diff9[alu8_pkg::DATA_W-1:0];
                n = 1'b1;
                h = diff_lo[4];
                c = diff9[alu8_pkg::DATA_W];
                zero_from_r = 1'b1;
            end
            alu8_pkg::FUNC_CP: begin
                // flags of sub, accumulator unchanged
                n = 1'b1;
                h = diff_lo[4];
                c = diff9[alu8_pkg::DATA_W];
                z = (diff9[alu8_pkg::DATA_W-1:0] == '0);
            end
            alu8_pkg::FUNC_AND: begin
                r = a & v; n = 1'b0; h = 1'b1; c = 1'b0; zero_from_r = 1'b1;
            end
            alu8_pkg::FUNC_XOR: begin
                r = a ^ v; n = 1'b0; h = 1'b0; c = 1'b0; zero_from_r = 1'b1;
            end
            alu8_pkg::FUNC_OR: begin
                r = a | v; n = 1'b0; h = 1'b0; c = 1'b0; zero_from_r = 1'b1;
            end
            alu8_pkg::FUNC_INC: begin
                r = v + 8'd1;
                n = 1'b0;
                h = (v[3:0] == alu8_pkg::NIBBLE_MAX);
                zero_from_r = 1'b1;
            end
            alu8_pkg::FUNC_DEC: begin
                r = v - 8'd1;
                n = 1'b1;
                h = (v[3:0] == 4'd0);
                zero_from_r = 1'b1;
            end
            alu8_pkg::FUNC_RLCA: begin
                r = {a[6:0], a[7]}; c = a[7]; z = 1'b0; n = 1'b0; h = 1'b0;
            end
            alu8_pkg::FUNC_RRCA: begin
                r = {a[0], a[7:1]}; c = a[0]; z = 1'b0; n = 1'b0; h = 1'b0;
            end
            alu8_pkg::FUNC_RLA: begin
                r = {a[6:0], i_item.carry_in}; c = a[7]; z = 1'b0; n = 1'b0; h = 1'b0;
            end
            alu8_pkg::FUNC_RRA: begin
                r = {i_item.carry_in, a[7:1]}; c = a[0]; z = 1'b0; n = 1'b0; h = 1'b0;
            end
            alu8_pkg::FUNC_DAA: begin
                r = i_item.subtract_in ? (a - daa_adj) : (a + daa_adj);
                if (!i_item.subtract_in && daa_hi) begin
                    c = 1'b1;
                end
                h = 1'b0;
                zero_from_r = 1'b1;
            end
            alu8_pkg::FUNC_CPL: begin
                r = a ^ alu8_pkg::BYTE_ONES; n = 1'b1; h = 1'b1;
            end
            alu8_pkg::FUNC_SCF: begin
                n = 1'b0; h = 1'b0; c = 1'b1;
            end
            alu8_pkg::FUNC_CCF: begin
                n = 1'b0; h = 1'b0; c = ~i_item.carry_in;
            end
            alu8_pkg::FUNC_RLC: begin
                r = {v[6:0], v[7]}; c = v[7]; n = 1'b0; h = 1'b0; zero_from_r = 1'b1;
            end
            alu8_pkg::FUNC_RRC: begin
                r = {v[0], v[7:1]}; c = v[0]; n = 1'b0; h = 1'b0; zero_from_r = 1'b1;
            end
            alu8_pkg::FUNC_RL: begin
                r = {v[6:0], i_item.carry_in}; c = v[7]; n = 1'b0; h = 1'b0;
                zero_from_r = 1'b1;
            end
            alu8_pkg::FUNC_RR: begin
                r = {i_item.carry_in, v[7:1]}; c = v[0]; n = 1'b0; h = 1'b0;
                zero_from_r = 1'b1;
            end
            alu8_pkg::FUNC_SLA: begin
                r = {v[6:0], 1'b0}; c = v[7]; n = 1'b0; h = 1'b0; zero_from_r = 1'b1;
            end
            alu8_pkg::FUNC_SRA: begin
                r = {v[7], v[7:1]}; c = v[0]; n = 1'b0; h = 1'b0; zero_from_r = 1'b1;
            end
            alu8_pkg::FUNC_SWAP: begin
                r = {v[3:0], v[7:4]}; n = 1'b0; h = 1'b0; c = 1'b0; zero_from_r = 1'b1;
            end
            alu8_pkg::FUNC_BIT: begin
                r = v;
                z = ~|(v & bit_mask);
                n = 1'b0;
                h = 1'b1;
            end
            alu8_pkg::FUNC_RES: begin
                r = v & ~bit_mask;
            end
            alu8_pkg::FUNC_SET: begin
                r = v | bit_mask;
            end
            default: begin
                r = a;
            end
        endcase
        if (zero_from_r) begin
            z = (r == '0);
        end
    end

    assign o_item.result         = r;
    assign o_item.zero_out       = z;
    assign o_item.subtract_out   = n;
    assign o_item.half_carry_out = h;
    assign o_item.carry_out      = c;

endmodule

>>> hdl/eight_bit_alu_with_flags_core.sv
`timescale 1ns / 1ps

// eight-bit alu with flags: each input transfer carries an operation code, the
// accumulator, an operand, a bit index and the four incoming flags (zero,
// subtract, half-carry, carry); each output transfer carries the result byte and
// the four new flags, one result per input, in order. the block takes one
// transfer per cycle at full rate while the output is not stalled, and a result
// reaches the output through two registers: the input register is written at the
// accepting edge, and one pass through the alu logic lands in the result register
// once that register is empty or being drained. that single alu pass between the
// two registers sets the clock limit. when the output is stalled the result
// register holds and the input register can still take one more transfer; ready
// drops only when both registers are full and the sink is not ready. flags an
// operation does not touch are passed through from the inputs, and unused
// operation codes return the accumulator with all flags passed through. there is
// no configuration and no state beyond the pipeline.

module eight_bit_alu_with_flags_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    alu8_in_if.sink     i_req,
    alu8_out_if.source  o_rsp
);

    // input register stage
    logic                r_in_vld;
    alu8_pkg::t_in_item  r_in;
    // result register stage
    logic                r_out_vld;
    alu8_pkg::t_out_item r_out;

    alu8_pkg::t_out_item n_out;
    logic                stage_adv;
    logic                in_xfer;

    // result register can take a new value when empty or being drained
    assign stage_adv = !r_out_vld || o_rsp.ready;
    assign i_req.ready = !r_in_vld || stage_adv;
    assign in_xfer = i_req.valid && i_req.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_req.ready) begin
            r_in_vld <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_in.func          <= alu8_pkg::t_func'(i_req.func);
            r_in.accumulator   <= i_req.accumulator;
            r_in.operand       <= i_req.operand;
            r_in.bit_index     <= i_req.bit_index;
            r_in.zero_in       <= i_req.zero_in;
            r_in.subtract_in   <= i_req.subtract_in;
            r_in.half_carry_in <= i_req.half_carry_in;
            r_in.carry_in      <= i_req.carry_in;
        end
    end

    // the whole operation in one combinational pass
    alu8_exec u_exec (
        .i_item (r_in),
        .o_item (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (stage_adv) begin
            r_out_vld <= r_in_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (stage_adv && r_in_vld) begin
            r_out <= n_out;
        end
    end

    assign o_rsp.valid          = r_out_vld;
    assign o_rsp.result         = r_out.result;
    assign o_rsp.zero_out       = r_out.zero_out;
    assign o_rsp.subtract_out   = r_out.subtract_out;
    assign o_rsp.half_carry_out = r_out.half_carry_out;
    assign o_rsp.carry_out      = r_out.carry_out;

`ifndef SYNTHESIS
    // an accepted transfer always lands in the input register
    a_in_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> r_in_vld)
        else $error("accepted transfer not held in input register");

    // a blocked input item is neither dropped nor altered
    a_in_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_vld && !stage_adv) |=> (r_in_vld && $stable(r_in)))
        else $error("blocked input item lost or changed");

    // an item that moves forward shows up as a result
    a_out_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_vld && stage_adv) |=> o_rsp.valid)
        else $error("advanced item did not reach result register");

    // compare leaves the accumulator as the result
    a_cp_keeps_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_vld && stage_adv && (r_in.func == alu8_pkg::FUNC_CP))
        |=> (o_rsp.result == $past(r_in.accumulator)))
        else $error("compare changed the accumulator");
`endif

endmodule

>>> test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import alu8_pkg::*;

    // codes outside the defined operation set, must pass the accumulator through
    localparam logic [FUNC_W-1:0] FUNC_SPARE_LO = 5'd28;
    localparam logic [FUNC_W-1:0] FUNC_SPARE_HI = 5'd31;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int STALL_CYCLES = 400;
    localparam int MAX_REPORTS  = 10;

    typedef struct packed {
        logic [FUNC_W-1:0]  func;
        logic [DATA_W-1:0]  acc;
        logic [DATA_W-1:0]  opnd;
        logic [INDEX_W-1:0] idx;
        logic               z;
        logic               n;
        logic               h;
        logic               c;
    } alu_req_t;

    typedef struct packed {
        alu_req_t  req;
        t_out_item rsp;
    } alu_due_t;

    typedef struct packed {
        alu_req_t  req;
        logic      typed;
        t_out_item rsp;
    } dir_row_t;

    localparam int DIR_ROWS = 32;

    // directed table: typed results only where they are obvious, the rest are predicted
    localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
        '{'{FUNC_ADD,  8'hFF, 8'h01, 3'd0, 1'b0, 1'b0, 1'b0, 1'b0},
          1'b1, '{8'h00, 1'b1, 1'b0, 1'b1, 1'b1}},
        '{'{FUNC_ADC,  8'hFF, 8'hFF, 3'd0, 1'b0, 1'b0, 1'b0, 1'b1},
          1'b1, '{8'hFF, 1'b0, 1'b0, 1'b1, 1'b1}},
        '{'{FUNC_SUB,  8'h00, 8'h01, 3'd0, 1'b0, 1'b0, 1'b0, 1'b0},
          1'b1, '{8'hFF, 1'b0, 1'b1, 1'b1, 1'b1}},
        '{'{FUNC_SBC,  8'h00, 8'hFF, 3'd0, 1'b0, 1'b0, 1'b0, 1'b1},
          1'b1, '{8'h00, 1'b1, 1'b1, 1'b1, 1'b1}},
        '{'{FUNC_AND,  8'hF0, 8'h0F, 3'd0, 1'b0, 1'b1, 1'b0, 1'b1},
          1'b1, '{8'h00, 1'b1, 1'b0, 1'b1, 1'b0}},
        '{'{FUNC_XOR,  8'hFF, 8'hFF, 3'd0, 1'b0, 1'b1, 1'b1, 1'b1},
          1'b1, '{8'h00, 1'b1, 1'b0, 1'b0, 1'b0}},
        '{'{FUNC_OR,   8'h00, 8'h00, 3'd0, 1'b1, 1'b1, 1'b1, 1'b1},
          1'b1, '{8'h00, 1'b1, 1'b0, 1'b0, 1'b0}},
        '{'{FUNC_CP,   8'h3C, 8'h3C, 3'd0, 1'b0, 1'b0, 1'b0, 1'b0},
          1'b1, '{8'h3C, 1'b1, 1'b1, 1'b0, 1'b0}},
        '{'{FUNC_INC,  8'h12, 8'hFF, 3'd0, 1'b0, 1'b1, 1'b0, 1'b1},
          1'b1, '{8'h00, 1'b1, 1'b0, 1'b1, 1'b1}},
        '{'{FUNC_DEC,  8'h12, 8'h00, 3'd0, 1'b1, 1'b0, 1'b0, 1'b0},
          1'b1, '{8'hFF, 1'b0, 1'b1, 1'b1, 1'b0}},
        '{'{FUNC_RLCA, 8'h80, 8'h00, 3'd0, 1'b1, 1'b1, 1'b1, 1'b0},
          1'b1, '{8'h01, 1'b0, 1'b0, 1'b0, 1'b1}},
        // zero result, zero flag still cleared
        '{'{FUNC_RRCA, 8'h00, 8'hFF, 3'd0, 1'b1, 1'b1, 1'b1, 1'b1},
          1'b1, '{8'h00, 1'b0, 1'b0, 1'b0, 1'b0}},
        '{'{FUNC_RLA,  8'h80, 8'h00, 3'd0, 1'b1, 1'b0, 1'b0, 1'b0},
          1'b1, '{8'h00, 1'b0, 1'b0, 1'b0, 1'b1}},
        '{'{FUNC_RRA,  8'h01, 8'h00, 3'd0, 1'b0, 1'b0, 1'b0, 1'b1},
          1'b1, '{8'h80, 1'b0, 1'b0, 1'b0, 1'b1}},
        // both adjust tests on the unadjusted accumulator
        '{'{FUNC_DAA,  8'h9A, 8'h00, 3'd0, 1'b0, 1'b0, 1'b0, 1'b0},
          1'b1, '{8'h00, 1'b1, 1'b0, 1'b0, 1'b1}},
        '{'{FUNC_DAA,  8'h00, 8'h00, 3'd0, 1'b0, 1'b1, 1'b1, 1'b1},
          1'b0, '0},
        '{'{FUNC_DAA,  8'h45, 8'h00, 3'd0, 1'b0, 1'b0, 1'b1, 1'b0},
          1'b0, '0},
        '{'{FUNC_CPL,  8'hA5, 8'h00, 3'd0, 1'b1, 1'b0, 1'b0, 1'b0},
          1'b1, '{8'h5A, 1'b1, 1'b1, 1'b1, 1'b0}},
        '{'{FUNC_SCF,  8'h77, 8'h00, 3'd0, 1'b1, 1'b1, 1'b1, 1'b0},
          1'b1, '{8'h77, 1'b1, 1'b0, 1'b0, 1'b1}},
        '{'{FUNC_CCF,  8'h00, 8'h00, 3'd0, 1'b0, 1'b1, 1'b1, 1'b1},
          1'b1, '{8'h00, 1'b0, 1'b0, 1'b0, 1'b0}},
        '{'{FUNC_RLC,  8'h5A, 8'h00, 3'd0, 1'b0, 1'b1, 1'b1, 1'b1},
          1'b1, '{8'h00, 1'b1, 1'b0, 1'b0, 1'b0}},
        '{'{FUNC_RRC,  8'h5A, 8'h01, 3'd0, 1'b1, 1'b0, 1'b0, 1'b0},
          1'b0, '0},
        '{'{FUNC_RL,   8'h5A, 8'h80, 3'd0, 1'b0, 1'b0, 1'b0, 1'b0},
          1'b1, '{8'h00, 1'b1, 1'b0, 1'b0, 1'b1}},
        '{'{FUNC_RR,   8'h5A, 8'h01, 3'd0, 1'b0, 1'b1, 1'b1, 1'b0},
          1'b0, '0},
        '{'{FUNC_SLA,  8'h5A, 8'hFF, 3'd0, 1'b1, 1'b1, 1'b1, 1'b0},
          1'b0, '0},
        '{'{FUNC_SRA,  8'h5A, 8'h81, 3'd0, 1'b1, 1'b1, 1'b1, 1'b0},
          1'b0, '0},
        '{'{FUNC_SWAP, 8'h5A, 8'hF0, 3'd0, 1'b1, 1'b1, 1'b1, 1'b1},
          1'b0, '0},
        '{'{FUNC_BIT,  8'h5A, 8'h7F, 3'd7, 1'b0, 1'b1, 1'b0, 1'b1},
          1'b1, '{8'h7F, 1'b1, 1'b0, 1'b1, 1'b1}},
        '{'{FUNC_BIT,  8'h5A, 8'h80, 3'd7, 1'b1, 1'b1, 1'b0, 1'b0},
          1'b0, '0},
        '{'{FUNC_RES,  8'h5A, 8'hFF, 3'd0, 1'b1, 1'b0, 1'b1, 1'b0},
          1'b1, '{8'hFE, 1'b1, 1'b0, 1'b1, 1'b0}},
        '{'{FUNC_SET,  8'h5A, 8'h00, 3'd7, 1'b0, 1'b1, 1'b0, 1'b1},
          1'b1, '{8'h80, 1'b0, 1'b1, 1'b0, 1'b1}},
        '{'{FUNC_SPARE_HI, 8'hC3, 8'h00, 3'd0, 1'b1, 1'b1, 1'b1, 1'b1},
          1'b1, '{8'hC3, 1'b1, 1'b1, 1'b1, 1'b1}}
    };

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    alu8_in_if  req_if ();
    alu8_out_if rsp_if ();

    eight_bit_alu_with_flags_core dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    alu_due_t results_due[$];
    int       err_cnt      = 0;
    int       cycle_cnt    = 0;
    int       src_idle_pct = 0;
    int       snk_idle_pct = 0;
    bit       stall_arm    = 1'b0;
    int       stall_left   = 0;

    // flag and result behavior of the alu, one request at a time
    function automatic t_out_item alu_compute(alu_req_t q);
        t_out_item         o;
        logic [DATA_W:0]   wide;
        logic [4:0]        nib;
        logic              cin;
        logic [DATA_W-1:0] r;
        logic              z, n, h, c, zr;
        r    = q.acc;
        z    = q.z;
        n    = q.n;
        h    = q.h;
        c    = q.c;
        zr   = 1'b0;
        cin  = 1'b0;
        wide = '0;
        nib  = '0;
        case (q.func)
            FUNC_ADD, FUNC_ADC: begin
                cin  = (q.func == FUNC_ADC) ? q.c : 1'b0;
                wide = {1'b0, q.acc} + {1'b0, q.opnd} + {8'd0, cin};
                nib  = {1'b0, q.acc[3:0]} + {1'b0, q.opnd[3:0]} + {4'd0, cin};
                r    = wide[DATA_W-1:0];
                n    = 1'b0;
                h    = nib[4];
                c    = wide[DATA_W];
                zr   = 1'b1;
            end
            FUNC_SUB, FUNC_SBC, FUNC_CP: begin
                // borrow shows up in the bit above the field
                cin  = (q.func == FUNC_SBC) ? q.c : 1'b0;
                wide = {1'b0, q.acc} - {1'b0, q.opnd} - {8'd0, cin};
                nib  = {1'b0, q.acc[3:0]} - {1'b0, q.opnd[3:0]} - {4'd0, cin};
                r    = wide[DATA_W-1:0];
                n    = 1'b1;
                h    = nib[4];
                c    = wide[DATA_W];
                z    = (r == '0);
                if (q.func == FUNC_CP) begin
                    r = q.acc;
                end
            end
            FUNC_AND: begin
                r = q.acc & q.opnd; n = 1'b0; h = 1'b1; c = 1'b0; zr = 1'b1;
            end
            FUNC_XOR: begin
                r = q.acc ^ q.opnd; n = 1'b0; h = 1'b0; c = 1'b0; zr = 1'b1;
            end
            FUNC_OR: begin
                r = q.acc | q.opnd; n = 1'b0; h = 1'b0; c = 1'b0; zr = 1'b1;
            end
            FUNC_INC: begin
                r = q.opnd + 8'd1; n = 1'b0; h = (q.opnd[3:0] == 4'hF); zr = 1'b1;
            end
            FUNC_DEC: begin
                r = q.opnd - 8'd1; n = 1'b1; h = (q.opnd[3:0] == 4'h0); zr = 1'b1;
            end
            FUNC_RLCA: begin
                c = q.acc[7]; r = {q.acc[6:0], q.acc[7]}; z = 1'b0; n = 1'b0; h = 1'b0;
            end
            FUNC_RRCA: begin
                c = q.acc[0]; r = {q.acc[0], q.acc[7:1]}; z = 1'b0; n = 1'b0; h = 1'b0;
            end
            FUNC_RLA: begin
                c = q.acc[7]; r = {q.acc[6:0], q.c}; z = 1'b0; n = 1'b0; h = 1'b0;
            end
            FUNC_RRA: begin
                c = q.acc[0]; r = {q.c, q.acc[7:1]}; z = 1'b0; n = 1'b0; h = 1'b0;
            end
            FUNC_DAA: begin
                if (!q.n) begin
                    if (q.c || q.acc > 8'h99) begin
                        r = r + 8'h60;
                        c = 1'b1;
                    end
                    if (q.h || q.acc[3:0] > 4'h9) begin
                        r = r + 8'h06;
                    end
                end else begin
                    if (q.c) begin
                        r = r - 8'h60;
                    end
                    if (q.h) begin
                        r = r - 8'h06;
                    end
                end
                h  = 1'b0;
                zr = 1'b1;
            end
            FUNC_CPL: begin
                r = ~q.acc; n = 1'b1; h = 1'b1;
            end
            FUNC_SCF: begin
                n = 1'b0; h = 1'b0; c = 1'b1;
            end
            FUNC_CCF: begin
                n = 1'b0; h = 1'b0; c = ~q.c;
            end
            FUNC_RLC: begin
                c = q.opnd[7]; r = {q.opnd[6:0], q.opnd[7]}; n = 1'b0; h = 1'b0; zr = 1'b1;
            end
            FUNC_RRC: begin
                c = q.opnd[0]; r = {q.opnd[0], q.opnd[7:1]}; n = 1'b0; h = 1'b0; zr = 1'b1;
            end
            FUNC_RL: begin
                c = q.opnd[7]; r = {q.opnd[6:0], q.c}; n = 1'b0; h = 1'b0; zr = 1'b1;
            end
            FUNC_RR: begin
                c = q.opnd[0]; r = {q.c, q.opnd[7:1]}; n = 1'b0; h = 1'b0; zr = 1'b1;
            end
            FUNC_SLA: begin
                c = q.opnd[7]; r = {q.opnd[6:0], 1'b0}; n = 1'b0; h = 1'b0; zr = 1'b1;
            end
            FUNC_SRA: begin
                c = q.opnd[0]; r = {q.opnd[7], q.opnd[7:1]}; n = 1'b0; h = 1'b0; zr = 1'b1;
            end
            FUNC_SWAP: begin
                r = {q.opnd[3:0], q.opnd[7:4]}; n = 1'b0; h = 1'b0; c = 1'b0; zr = 1'b1;
            end
            FUNC_BIT: begin
                r = q.opnd; z = ~q.opnd[q.idx]; n = 1'b0; h = 1'b1;
            end
            FUNC_RES: begin
                r = q.opnd & ~(8'h01 << q.idx);
            end
            FUNC_SET: begin
                r = q.opnd | (8'h01 << q.idx);
            end
            default: begin
                r = q.acc;
            end
        endcase
        if (zr) begin
            z = (r == '0);
        end
        o.result         = r;
        o.zero_out       = z;
        o.subtract_out   = n;
        o.half_carry_out = h;
        o.carry_out      = c;
        return o;
    endfunction

    // bytes biased toward the edges the flag logic cares about
    function automatic logic [DATA_W-1:0] pick_byte();
        logic [DATA_W-1:0] b;
        case ($urandom_range(7))
            0:       b = 8'h00;
            1:       b = 8'hFF;
            2:       b = $urandom_range(1) ? 8'h80 : 8'h7F;
            3:       b = {4'($urandom_range(15)), 4'($urandom_range(10, 9))};
            4:       b = {4'($urandom_range(15)), $urandom_range(1) ? 4'hF : 4'h0};
            default: b = 8'($urandom);
        endcase
        return b;
    endfunction

    function automatic alu_req_t random_req();
        alu_req_t q;
        if ($urandom_range(15) == 0) begin
            q.func = 5'($urandom_range(FUNC_SPARE_HI, FUNC_SPARE_LO));
        end else begin
            q.func = 5'($urandom_range(FUNC_SET, FUNC_ADD));
        end
        q.acc  = pick_byte();
        q.opnd = pick_byte();
        q.idx  = 3'($urandom_range(7));
        q.z    = 1'($urandom_range(1));
        q.n    = 1'($urandom_range(1));
        q.h    = 1'($urandom_range(1));
        q.c    = 1'($urandom_range(1));
        return q;
    endfunction

    // entered and left at a falling edge; the result is queued on transfer
    task automatic send_op(input alu_req_t q, input t_out_item due);
        while ($urandom_range(99) < src_idle_pct) begin
            req_if.valid <= 1'b0;
            @(negedge clk);
        end
        req_if.valid         <= 1'b1;
        req_if.func          <= q.func;
        req_if.accumulator   <= q.acc;
        req_if.operand       <= q.opnd;
        req_if.bit_index     <= q.idx;
        req_if.zero_in       <= q.z;
        req_if.subtract_in   <= q.n;
        req_if.half_carry_in <= q.h;
        req_if.carry_in      <= q.c;
        do begin
            @(posedge clk);
        end while (!req_if.ready);
        results_due.push_back('{q, due});
        @(negedge clk);
    endtask

    task automatic send_random(input int count);
        alu_req_t q;
        for (int i = 0; i < count; i++) begin
            q = random_req();
            send_op(q, alu_compute(q));
        end
    endtask

    // sender holds off until every pending result has come back
    task automatic drain_results();
        req_if.valid <= 1'b0;
        while (results_due.size() != 0) begin
            @(posedge clk);
        end
        @(negedge clk);
    endtask

    // sink side: random back-pressure plus an armed long hold-off
    initial begin
        rsp_if.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (stall_arm) begin
                stall_arm  = 1'b0;
                stall_left = STALL_CYCLES;
            end
            if (stall_left != 0) begin
                stall_left--;
                rsp_if.ready <= 1'b0;
            end else begin
                rsp_if.ready <= ($urandom_range(99) >= snk_idle_pct);
            end
        end
    end

    // result checker, in order against the oldest pending result
    initial begin
        alu_due_t  due;
        t_out_item got;
        forever begin
            @(posedge clk);
            if (rst_n && rsp_if.valid && rsp_if.ready) begin
                got = '{rsp_if.result, rsp_if.zero_out, rsp_if.subtract_out,
                        rsp_if.half_carry_out, rsp_if.carry_out};
                if (results_due.size() == 0) begin
                    err_cnt++;
                    if (err_cnt <= MAX_REPORTS) begin
                        $display("unexpected transfer: result %02h flags z%b n%b h%b c%b",
                                 got.result, got.zero_out, got.subtract_out,
                                 got.half_carry_out, got.carry_out);
                    end
                end else begin
                    due = results_due.pop_front();
                    if (got.result !== due.rsp.result
                            || got.zero_out !== due.rsp.zero_out
                            || got.subtract_out !== due.rsp.subtract_out
                            || got.half_carry_out !== due.rsp.half_carry_out
                            || got.carry_out !== due.rsp.carry_out) begin
                        err_cnt++;
                        if (err_cnt <= MAX_REPORTS) begin
                            $display("mismatch func %0d a %02h v %02h idx %0d in z%b n%b h%b c%b",
                                     due.req.func, due.req.acc, due.req.opnd, due.req.idx,
                                     due.req.z, due.req.n, due.req.h, due.req.c);
                            $display("  expected %02h z%b n%b h%b c%b, got %02h z%b n%b h%b c%b",
                                     due.rsp.result, due.rsp.zero_out, due.rsp.subtract_out,
                                     due.rsp.half_carry_out, due.rsp.carry_out,
                                     got.result, got.zero_out, got.subtract_out,
                                     got.half_carry_out, got.carry_out);
                        end
                    end
                end
            end
        end
    end

    always @(posedge clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        req_if.valid         = 1'b0;
        req_if.func          = '0;
        req_if.accumulator   = '0;
        req_if.operand       = '0;
        req_if.bit_index     = '0;
        req_if.zero_in       = 1'b0;
        req_if.subtract_in   = 1'b0;
        req_if.half_carry_in = 1'b0;
        req_if.carry_in      = 1'b0;
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed table at full rate
        for (int i = 0; i < DIR_ROWS; i++) begin
            send_op(DIR_TABLE[i].req,
                    DIR_TABLE[i].typed ? DIR_TABLE[i].rsp : alu_compute(DIR_TABLE[i].req));
        end
        drain_results();

        // light sender gaps, heavy sink back-pressure
        src_idle_pct = 14;
        snk_idle_pct = 77;
        send_random(430);
        drain_results();

        // the other way round
        src_idle_pct = 77;
        snk_idle_pct = 14;
        send_random(430);
        drain_results();

        // no idling; a long sink hold-off first so the pipe fills and input stalls
        src_idle_pct = 0;
        snk_idle_pct = 0;
        stall_arm    = 1'b1;
        send_random(60);
        send_random(380);

        drain_results();
        repeat (8) @(posedge clk);
        if (err_cnt == 0 && results_due.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

>>> eight_bit_alu_with_flags_core.f
hdl/alu8_pkg.sv
hdl/alu8_in_if.sv
hdl/alu8_out_if.sv
hdl/alu8_exec.sv
hdl/eight_bit_alu_with_flags_core.sv
test/tb_top.sv
